### rtl/weighted_power_moment_top_macros.svh
// Assertion macros used by the checker file of the weighted power moment block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef WEIGHTED_POWER_MOMENT_TOP_MACROS_SVH
`define WEIGHTED_POWER_MOMENT_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/wpm_pkg.sv
`timescale 1ns / 1ps

package wpm_pkg;

	// Depth of the queue between the front end and the back end.
	localparam int QDEPTH = 2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_POWER_K  = CFG_IDX_W'(1);

	// Reset values of the configuration registers.
	localparam logic [31:0] OFFSET_A_RESET = 32'd0;
	localparam logic [3:0]  POWER_K_RESET  = 4'd2;

	// One classified request as it travels from the front end to the back end.
	typedef struct packed {
		logic [63:0] d;     // offset weighted sample, signed fixed point
		logic [31:0] w;     // sample weight, signed fixed point
		logic        last;  // closes the current set
	} entry_t;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_PACK,
		B_ACC,
		B_FIN,
		B_DIV,
		B_QPACK,
		B_OUT
	} back_state_t;

endpackage

### rtl/weighted_power_moment_top.sv
`timescale 1ns / 1ps

// Weighted power moment of a sample stream, Q16.16 fixed point by default.
// Input queue side: sample_u, weight_w and last_item are taken when push is high
// and full is low. Each sample forms d = w*u - offset_a, raised to power_k, and
// the terms and weights are summed. A request with last_item set closes the set.
// Result queue side: while empty is low, moment, divide_by_zero and overflowed
// show the oldest result; pop takes it. One result per set.
// Configuration: cfg_index selects offset_a (0) or power_k (1); cfg_data is
// written when cfg_valid is high (cfg_ready is always high). Write only while idle.
// Sequencing: the back end takes one request at a time; for power_k above 1 it uses the
// shared 32x32 multiplier that forms each power product in four partial products.
// A closing request then runs the one-bit-per-cycle divider and loads the result
// register, or skips the divider and only loads the result when the weight sum is zero.
// A two-entry queue lets requests keep arriving while the back end works; full
// rises only when both entries and the front-end stage are occupied. When the
// receiver stalls, the result waits in the output register and requests are still
// taken until the internal storage fills. Reset clears the sums, the saturation
// flag, all queues and the configuration (offset_a = 0, power_k = 2).
module weighted_power_moment_top #(
	parameter int MAX_POWER = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [31:0]                   sample_u,
	input  logic [31:0]                   weight_w,
	input  logic                          last_item,
	output logic                          empty,
	input  logic                          pop,
	output logic [63:0]                   moment,
	output logic                          divide_by_zero,
	output logic                          overflowed,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wpm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import wpm_pkg::*;

	logic [31:0] offset_a_q;
	logic [3:0]  power_k_q;
	logic        q_push;
	logic        q_full;
	logic        q_pop;
	logic        q_empty;
	entry_t      q_wr_entry;
	entry_t      q_rd_entry;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_a_q <= OFFSET_A_RESET;
			power_k_q  <= POWER_K_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_OFFSET_A: offset_a_q <= cfg_data;
				REG_POWER_K:  power_k_q  <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// Front end: product of weight and sample, offset removal.
	wpm_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.sample_u (sample_u),
		.weight_w (weight_w),
		.last_item(last_item),
		.offset_a (offset_a_q),
		.q_full   (q_full),
		.full     (full),
		.q_push   (q_push),
		.q_entry  (q_wr_entry)
	);

	// Queue between front end and back end.
	wpm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_entry(q_wr_entry),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.rd_entry(q_rd_entry)
	);

	// Back end: power loop, sums, divider and result register.
	wpm_back #(
		.MAX_POWER(MAX_POWER),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.power_k       (power_k_q),
		.q_empty       (q_empty),
		.q_head        (q_rd_entry),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.moment        (moment),
		.divide_by_zero(divide_by_zero),
		.overflowed    (overflowed)
	);

endmodule

### rtl/wpm_front.sv
`timescale 1ns / 1ps

module wpm_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic [31:0]     sample_u,
	input  logic [31:0]     weight_w,
	input  logic            last_item,
	input  logic [31:0]     offset_a,
	input  logic            q_full,
	output logic            full,
	output logic            q_push,
	output wpm_pkg::entry_t q_entry
);
	import wpm_pkg::*;

	logic        take;
	logic        s1_valid_q;
	logic [31:0] u_mag;
	logic [31:0] w_mag;
	logic [63:0] prod;
	logic [63:0] prod_s1;
	logic        neg_s1;
	logic [31:0] w_s1;
	logic        last_s1;
	logic [63:0] trunc;
	logic [63:0] d_raw;

	// The stage moves into the queue whenever the queue has room.
	assign q_push = s1_valid_q & ~q_full;
	assign full   = s1_valid_q & q_full;
	assign take   = push & ~full;

	// Magnitude product of weight and sample.
	always_comb begin
		u_mag = sample_u[31] ? (~sample_u + 32'd1) : sample_u;
		w_mag = weight_w[31] ? (~weight_w + 32'd1) : weight_w;
		prod  = {32'd0, u_mag} * {32'd0, w_mag};
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (take) begin
			s1_valid_q <= 1'b1;
		end else if (q_push) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (take) begin
			prod_s1 <= prod;
			neg_s1  <= sample_u[31] ^ weight_w[31];
			w_s1    <= weight_w;
			last_s1 <= last_item;
		end
	end

	// Truncate toward zero, restore the sign, then remove the offset.
	always_comb begin
		trunc = prod_s1 >> FRAC_BITS;
		d_raw = neg_s1 ? (~trunc + 64'd1) : trunc;
		q_entry.d    = d_raw - {{32{offset_a[31]}}, offset_a};
		q_entry.w    = w_s1;
		q_entry.last = last_s1;
	end

endmodule

### rtl/wpm_queue.sv
`timescale 1ns / 1ps

module wpm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  wpm_pkg::entry_t wr_entry,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output wpm_pkg::entry_t rd_entry
);
	import wpm_pkg::*;

	localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	entry_t         slots_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;
	logic           do_push;
	logic           do_pop;

	assign full     = (count_q == QCW'(QDEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign rd_entry = slots_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

### rtl/wpm_back.sv
`timescale 1ns / 1ps

module wpm_back #(
	parameter int MAX_POWER = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [3:0]      power_k,
	input  logic            q_empty,
	input  wpm_pkg::entry_t q_head,
	output logic            q_pop,
	input  logic            pop,
	output logic            empty,
	output logic [63:0]     moment,
	output logic            divide_by_zero,
	output logic            overflowed
);
	import wpm_pkg::*;

	localparam int KW   = $clog2(MAX_POWER + 1);
	localparam int DIVW = 64 + FRAC_BITS;
	localparam int DCW  = $clog2(DIVW + 1);

	back_state_t     state_q;
	back_state_t     state_d;

	logic [63:0]     d_mag_q;
	logic            d_neg_q;
	logic [31:0]     w_q;
	logic            last_q;
	logic [KW-1:0]   k_q;
	logic [KW-1:0]   j_q;
	logic [63:0]     term_mag_q;
	logic            term_neg_q;
	logic            item_sat_q;
	logic [2:0]      mcnt_q;
	logic [1:0]      pidx_q;
	logic [63:0]     pp_q;
	logic [127:0]    acc_q;
	logic [63:0]     term_sum_q;
	logic [63:0]     weight_sum_q;
	logic            sat_seen_q;
	logic [DIVW-1:0] div_q;
	logic [63:0]     rem_q;
	logic [63:0]     den_q;
	logic [DCW-1:0]  dcnt_q;
	logic            qneg_q;
	logic [63:0]     res_moment_q;
	logic            res_dz_q;
	logic            res_ovf_q;
	logic            out_valid_q;
	logic [63:0]     moment_q;
	logic            dz_q;
	logic            ovf_q;

	logic [KW-1:0]   k_clamp;
	logic [63:0]     head_mag;
	logic [31:0]     mul_a;
	logic [31:0]     mul_b;
	logic [63:0]     mul_p;
	logic [1:0]      psum;
	logic [127:0]    pp_shifted;
	logic [64:0]     term_pack;
	logic            prod_neg;
	logic [63:0]     term_signed;
	logic [64:0]     tsum_add;
	logic [64:0]     wsum_add;
	logic [63:0]     tsum_mag;
	logic [63:0]     wsum_mag;
	logic [64:0]     rem_shift;
	logic            rem_ge;
	logic [64:0]     rem_sub;
	logic [64:0]     quot_pack;
	logic            out_load;
	logic            last_mul;

	// Saturating pack of a magnitude with a sign: returns {saturated, magnitude}.
	function automatic logic [64:0] pack_mag(input logic [127:0] m, input logic neg);
		logic [63:0] lim;
		logic        sat;
		lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		sat = (m[127:64] != '0) || (m[63:0] > lim);
		return {sat, sat ? lim : m[63:0]};
	endfunction

	// Saturating signed add: returns {saturated, sum}.
	function automatic logic [64:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		logic        ovf;
		r   = a + b;
		ovf = (a[63] == b[63]) && (r[63] != a[63]);
		if (ovf) begin
			r = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end
		return {ovf, r};
	endfunction

	// Exponent clamp and head magnitude.
	always_comb begin
		if (power_k == 4'd0) begin
			k_clamp = KW'(1);
		end else if (int'(power_k) > MAX_POWER) begin
			k_clamp = KW'(MAX_POWER);
		end else begin
			k_clamp = KW'(power_k);
		end
		head_mag = q_head.d[63] ? (~q_head.d + 64'd1) : q_head.d;
	end

	// Shared 32 by 32 multiplier: one partial product per cycle.
	always_comb begin
		mul_a      = mcnt_q[1] ? term_mag_q[63:32] : term_mag_q[31:0];
		mul_b      = mcnt_q[0] ? d_mag_q[63:32] : d_mag_q[31:0];
		mul_p      = {32'd0, mul_a} * {32'd0, mul_b};
		psum       = {1'b0, pidx_q[1]} + {1'b0, pidx_q[0]};
		pp_shifted = {64'd0, pp_q} << {psum, 5'd0};
		prod_neg   = term_neg_q ^ d_neg_q;
		term_pack  = pack_mag(acc_q >> FRAC_BITS, prod_neg);
		last_mul   = ((j_q + KW'(1)) == k_q);
	end

	// Running sums.
	always_comb begin
		term_signed = term_neg_q ? (~term_mag_q + 64'd1) : term_mag_q;
		tsum_add    = sat_add(term_sum_q, term_signed);
		wsum_add    = sat_add(weight_sum_q, {{32{w_q[31]}}, w_q});
		tsum_mag    = term_sum_q[63] ? (~term_sum_q + 64'd1) : term_sum_q;
		wsum_mag    = weight_sum_q[63] ? (~weight_sum_q + 64'd1) : weight_sum_q;
	end

	// Restoring divider step and quotient pack.
	always_comb begin
		rem_shift = {rem_q, div_q[DIVW-1]};
		rem_ge    = (rem_shift >= {1'b0, den_q});
		rem_sub   = rem_shift - {1'b0, den_q};
		quot_pack = pack_mag(128'(div_q), qneg_q);
	end

	// Sequencer next state and handshakes.
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = (k_clamp == KW'(1)) ? B_ACC : B_MUL;
				end
			end
			B_MUL: begin
				if (mcnt_q == 3'd4) begin
					state_d = B_PACK;
				end
			end
			B_PACK: begin
				state_d = last_mul ? B_ACC : B_MUL;
			end
			B_ACC: begin
				state_d = last_q ? B_FIN : B_IDLE;
			end
			B_FIN: begin
				state_d = (weight_sum_q == '0) ? B_OUT : B_DIV;
			end
			B_DIV: begin
				if (dcnt_q == DCW'(1)) begin
					state_d = B_QPACK;
				end
			end
			B_QPACK: begin
				state_d = B_OUT;
			end
			B_OUT: begin
				if (!out_valid_q || pop) begin
					out_load = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Set state: sums and saturation flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_sum_q   <= '0;
			weight_sum_q <= '0;
			sat_seen_q   <= 1'b0;
		end else if (state_q == B_ACC) begin
			term_sum_q   <= tsum_add[63:0];
			weight_sum_q <= wsum_add[63:0];
			sat_seen_q   <= sat_seen_q | item_sat_q | tsum_add[64] | wsum_add[64];
		end else if (out_load) begin
			term_sum_q   <= '0;
			weight_sum_q <= '0;
			sat_seen_q   <= 1'b0;
		end
	end

	// Working registers of the power loop and the divider.
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					d_mag_q    <= head_mag;
					d_neg_q    <= q_head.d[63];
					term_mag_q <= head_mag;
					term_neg_q <= q_head.d[63];
					w_q        <= q_head.w;
					last_q     <= q_head.last;
					k_q        <= k_clamp;
					j_q        <= KW'(1);
					item_sat_q <= 1'b0;
					mcnt_q     <= 3'd0;
					acc_q      <= '0;
				end
			end
			B_MUL: begin
				if (mcnt_q != 3'd4) begin
					pp_q   <= mul_p;
					pidx_q <= mcnt_q[1:0];
				end
				if (mcnt_q != 3'd0) begin
					acc_q <= acc_q + pp_shifted;
				end
				mcnt_q <= mcnt_q + 3'd1;
			end
			B_PACK: begin
				term_mag_q <= term_pack[63:0];
				term_neg_q <= prod_neg;
				item_sat_q <= item_sat_q | term_pack[64];
				j_q        <= j_q + KW'(1);
				mcnt_q     <= 3'd0;
				acc_q      <= '0;
			end
			B_FIN: begin
				if (weight_sum_q == '0) begin
					res_moment_q <= '0;
					res_dz_q     <= 1'b1;
					res_ovf_q    <= sat_seen_q;
				end else begin
					div_q  <= {tsum_mag, {FRAC_BITS{1'b0}}};
					den_q  <= wsum_mag;
					rem_q  <= '0;
					qneg_q <= term_sum_q[63] ^ weight_sum_q[63];
					dcnt_q <= DCW'(DIVW);
				end
			end
			B_DIV: begin
				rem_q  <= rem_ge ? rem_sub[63:0] : rem_shift[63:0];
				div_q  <= {div_q[DIVW-2:0], rem_ge};
				dcnt_q <= dcnt_q - DCW'(1);
			end
			B_QPACK: begin
				res_moment_q <= qneg_q ? (~quot_pack[63:0] + 64'd1) : quot_pack[63:0];
				res_dz_q     <= 1'b0;
				res_ovf_q    <= sat_seen_q | quot_pack[64];
			end
			default: begin
			end
		endcase
	end

	// Result register toward the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			moment_q <= res_moment_q;
			dz_q     <= res_dz_q;
			ovf_q    <= res_ovf_q;
		end
	end

	assign empty          = ~out_valid_q;
	assign moment         = moment_q;
	assign divide_by_zero = dz_q;
	assign overflowed     = ovf_q;

endmodule

### rtl/wpm_checker.sv
`timescale 1ns / 1ps

`include "weighted_power_moment_top_macros.svh"

module wpm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          push,
	input logic                          full,
	input logic [31:0]                   sample_u,
	input logic [31:0]                   weight_w,
	input logic                          last_item,
	input logic                          empty,
	input logic                          pop,
	input logic [63:0]                   moment,
	input logic                          divide_by_zero,
	input logic                          overflowed,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [wpm_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0]                   cfg_data
);

	// A waiting result holds until it is popped.
	`WPM_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(moment) && $stable(divide_by_zero) && $stable(overflowed), "result changed while stalled")

	// A zero weight sum always reports a zero moment.
	`WPM_ASSERT_SAME(a_dz_zero, !empty && divide_by_zero, moment == 64'd0, "divide by zero with nonzero moment")

	// The input side can only fill up right after taking a request.
	`WPM_ASSERT_SAME(a_full_cause, $rose(full), $past(push && !full), "full rose without an accepted request")

endmodule

bind weighted_power_moment_top wpm_checker u_wpm_checker (.*);
